/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* sv/bra_pkg.sv */
package bra_pkg;

    localparam int DEFAULT_MAP_BYTES = 128;
    localparam int OP_W              = 2;
    localparam int IDX_W             = 10;
    localparam int LEN_W             = 11;
    localparam int BYTE_W            = 8;
    localparam int BIT_SEL_W         = 3;
    localparam int IN_TDATA_W        = 24;
    localparam int OUT_TDATA_W       = 16;

    typedef enum logic [OP_W-1:0] {
        OP_SCAN  = 2'd0,
        OP_SET   = 2'd1,
        OP_TEST  = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_BIT_RD,
        S_BIT_EVAL,
        S_CLEAR,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] run;
        logic [IDX_W-1:0] start;
    } scan_state_t;

endpackage

/* sv/bitmap_run_allocator.sv */
// First-fit allocator over a bitmap of MAP_BYTES*8 bits (1 allocated, 0 free) held in a
// MAP_BYTES x 8 memory. tuser carries the opcode: scan for the lowest run of run_length free
// bits, set or clear a bit (set_value), test a bit, or clear the map; every request returns
// exactly one result. A scan walks the memory one byte per cycle through a byte scan unit;
// set and test go through read, modify/evaluate and result steps; clear writes one byte per
// cycle. Requests rejected at once (zero or too long run, index outside the map) go straight
// to the result. After reset a clearing pass over all MAP_BYTES bytes runs with s_axis_tready
// low. A finished result sits in an output register, so a new request is taken while an earlier
// result still waits. run_start is reported modulo 1024.
module bitmap_run_allocator #(
    parameter int MAP_BYTES = bra_pkg::DEFAULT_MAP_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // bit_index[9:0], run_length[20:10], set_value[21], zero pad
    input  logic [bra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode[1:0]
    input  logic [bra_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // found[0], run_start[10:1], bit_value[11], zero pad
    output logic [bra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bra_pkg::*;

    localparam int          AW           = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam logic [31:0] TOTAL_BITS   = 32'(MAP_BYTES * BYTE_W);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(MAP_BYTES - 1);

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                val_reg, val_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       paddr_reg, paddr_next;
    logic                pend_reg, pend_next;
    logic                issue_done_reg, issue_done_next;
    scan_state_t         scan_reg, scan_next;
    logic                res_found_reg, res_found_next;
    logic [IDX_W-1:0]    res_start_reg, res_start_next;
    logic                res_bit_reg, res_bit_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [IDX_W-1:0]    out_start_reg, out_start_next;
    logic                out_bit_reg, out_bit_next;

    logic                accept;
    opcode_t             in_op;
    logic [IDX_W-1:0]    in_idx;
    logic [LEN_W-1:0]    in_len;
    logic                in_val;
    logic                scan_reject;
    logic                idx_reject;
    logic                scan_done;
    logic                out_load;
    logic [AW-1:0]       byte_addr;
    logic [BYTE_W-1:0]   bit_mask;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    scan_state_t         unit_nxt;
    logic [IDX_W-1:0]    unit_base;

    assign in_op       = opcode_t'(s_axis_tuser);
    assign in_idx      = s_axis_tdata[IDX_W-1:0];
    assign in_len      = s_axis_tdata[IDX_W+LEN_W-1:IDX_W];
    assign in_val      = s_axis_tdata[IDX_W+LEN_W];
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign scan_reject = (in_len == '0) || (32'(in_len) > TOTAL_BITS);
    assign idx_reject  = (32'(in_idx) >= TOTAL_BITS);
    assign byte_addr   = AW'(idx_reg[IDX_W-1:BIT_SEL_W]);
    assign bit_mask    = BYTE_W'(1) << idx_reg[BIT_SEL_W-1:0];
    assign unit_base   = IDX_W'({paddr_reg, {BIT_SEL_W{1'b0}}});
    assign scan_done   = pend_reg && (unit_nxt.hit || (paddr_reg == LAST_ADDR));
    assign out_load    = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_bit_reg, out_start_reg, out_found_reg});

    bra_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bra_scan_unit u_scan_unit (
        .data (ram_rdata),
        .base (unit_base),
        .len  (len_reg),
        .cur  (scan_reg),
        .nxt  (unit_nxt)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_SCAN:  state_next = scan_reject ? S_PUSH : S_SCAN;
                        OP_SET:   state_next = idx_reject ? S_PUSH : S_BIT_RD;
                        OP_TEST:  state_next = idx_reject ? S_PUSH : S_BIT_RD;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_PUSH;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_BIT_RD:   state_next = S_BIT_EVAL;
            S_BIT_EVAL: state_next = S_PUSH;
            S_CLEAR:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_INIT;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next         = op_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        addr_next       = addr_reg;
        paddr_next      = paddr_reg;
        pend_next       = pend_reg;
        issue_done_next = issue_done_reg;
        scan_next       = scan_reg;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        res_bit_next    = res_bit_reg;
        out_found_next  = out_found_reg;
        out_start_next  = out_start_reg;
        out_bit_next    = out_bit_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        ram_raddr       = addr_reg;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    idx_next        = in_idx;
                    len_next        = in_len;
                    val_next        = in_val;
                    addr_next       = '0;
                    pend_next       = 1'b0;
                    issue_done_next = 1'b0;
                    scan_next       = '0;
                    res_found_next  = 1'b0;
                    res_start_next  = '0;
                    res_bit_next    = 1'b0;
                end
            end
            S_SCAN:
            begin
                pend_next  = !issue_done_reg;
                paddr_next = addr_reg;
                if (!issue_done_reg)
                begin
                    addr_next       = addr_reg + 1'b1;
                    issue_done_next = (addr_reg == LAST_ADDR);
                end
                if (pend_reg)
                begin
                    scan_next = unit_nxt;
                end
                if (scan_done)
                begin
                    res_found_next = unit_nxt.hit;
                    res_start_next = unit_nxt.hit ? unit_nxt.start : '0;
                end
            end
            S_BIT_RD:
            begin
                ram_raddr = byte_addr;
            end
            S_BIT_EVAL:
            begin
                ram_waddr = byte_addr;
                ram_wdata = val_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
                ram_we    = (op_reg == OP_SET);
                if (op_reg == OP_TEST)
                begin
                    res_bit_next = ram_rdata[idx_reg[BIT_SEL_W-1:0]];
                end
            end
            S_PUSH:
            begin
                if (out_load)
                begin
                    out_found_next = res_found_reg;
                    out_start_next = res_start_reg;
                    out_bit_next   = res_bit_reg;
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase

        priority if ((state_reg == S_PUSH) && out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            issue_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            pend_reg       <= pend_next;
            issue_done_reg <= issue_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        val_reg       <= val_next;
        paddr_reg     <= paddr_next;
        scan_reg      <= scan_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_bit_reg   <= res_bit_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_bit_reg   <= out_bit_next;
    end

endmodule

/* sv/bra_ram.sv */
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/bra_scan_unit.sv */
module bra_scan_unit (
    input  logic [bra_pkg::BYTE_W-1:0] data,
    input  logic [bra_pkg::IDX_W-1:0]  base,
    input  logic [bra_pkg::LEN_W-1:0]  len,
    input  bra_pkg::scan_state_t       cur,
    output bra_pkg::scan_state_t       nxt
);
    import bra_pkg::*;

    // walk the eight bits of one map byte, lowest first
    always_comb
    begin
        scan_state_t s;
        s = cur;
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (!s.hit)
            begin
                if (data[b])
                begin
                    s.run   = '0;
                    s.start = base + IDX_W'(b + 1);
                end
                else
                begin
                    s.run = s.run + 1'b1;
                end
                if (s.run == len)
                begin
                    s.hit = 1'b1;
                end
            end
        end
        nxt = s;
    end

endmodule

/* sv/bra_checker.sv */
`include "assert_macros.svh"

module bra_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [bra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [bra_pkg::OP_W-1:0]         s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // after every accepted request the block is busy (s_axis_tready low) in the next cycle
    `ASSERT_ALWAYS(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // a miss or a non-scan result reports start zero
    `ASSERT_NEVER(a_start_zero_on_miss, clk, rst_n, m_axis_tvalid && !m_axis_tdata[0] && (m_axis_tdata[10:1] != 10'd0))

    // found and bit_value come from different opcodes
    `ASSERT_NEVER(a_found_xor_bit, clk, rst_n, m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[11])

    // a stalled result transaction holds
    `ASSERT_ALWAYS(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);
